// File: design/cordic_sine_cosine_rotation_assert.svh
// Assertion macros for the CORDIC sine/cosine block.
// Included by the top level; expects aclk and aresetn in scope.
`ifndef CORDIC_SINE_COSINE_ROTATION_ASSERT_SVH
`define CORDIC_SINE_COSINE_ROTATION_ASSERT_SVH
`ifndef SYNTHESIS
`define CSC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);
`define CSC_ASSERT_NEVER(label, expr, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) !(expr)) else $error(msg);
`else
`define CSC_ASSERT(label, prop, msg)
`define CSC_ASSERT_NEVER(label, expr, msg)
`endif
`endif

// File: design/csc_pkg.sv
// Shared types, constants and ROM tables for the CORDIC sine/cosine block.
// No dependencies.
package csc_pkg;

    localparam int STAGES_DEF     = 32;
    localparam int DATA_WIDTH_DEF = 32;
    localparam int ROM_SIZE       = 32;
    localparam int ROM_IDX_W      = 5;
    localparam int ANGLE_W        = 24;
    localparam int RESULT_W       = 32;
    localparam int MAG_W          = 23;
    localparam int APB_ADDR_W     = 3;
    localparam int APB_DATA_W     = 32;

    localparam logic signed [ANGLE_W-1:0]  ANGLE_LIMIT = 24'sd5898240;
    localparam logic [40:0]                DEG2RAD_Q46 = 41'd1228166276394;
    localparam logic [20:0]                DEG2RAD_HI  = DEG2RAD_Q46[40:20];
    localparam logic [19:0]                DEG2RAD_LO  = DEG2RAD_Q46[19:0];
    localparam logic signed [RESULT_W-1:0] ONE_Q30     = 32'sd1073741824;

    // register map
    localparam logic [0:0]           REG_LAST_ITERATION = 1'b0;
    localparam logic [ROM_IDX_W-1:0] LAST_ITER_RESET    = 5'd31;

    typedef struct packed {
        logic signed [31:0] alpha;
        logic signed [31:0] target;
    } angle_t;

    typedef logic [ROM_SIZE-1:0][30:0] gain_rom_t;

    localparam logic [29:0] ATAN_ROM [ROM_SIZE] = '{
        30'd843314857, 30'd497837829, 30'd263043837, 30'd133525159, 30'd67021687,
        30'd33543516, 30'd16775851, 30'd8388437, 30'd4194283, 30'd2097149,
        30'd1048576, 30'd524288, 30'd262144, 30'd131072, 30'd65536, 30'd32768,
        30'd16384, 30'd8192, 30'd4096, 30'd2048, 30'd1024, 30'd512, 30'd256,
        30'd128, 30'd64, 30'd32, 30'd16, 30'd8, 30'd4, 30'd2, 30'd1, 30'd0
    };

    // Gain in Q30 for n = idx+1 rotations: largest g with g*g*P <= 2^121,
    // P = 2 in Q2.61 grown by P >> 2i per rotation.
    function automatic gain_rom_t build_gain_rom();
        gain_rom_t    rom;
        logic [63:0]  p;
        logic [30:0]  g;
        logic [30:0]  c;
        logic [127:0] cc;
        logic [127:0] prod;
        rom = '0;
        for (int n = 1; n <= ROM_SIZE; n++) begin
            p = 64'd1 << 62;
            for (int i = 1; i < n; i++) begin
                p = p + (p >> (2 * i));
            end
            g = '0;
            for (int b = 30; b >= 0; b--) begin
                c    = g | (31'd1 << b);
                cc   = 128'(c) * 128'(c);
                prod = cc * 128'(p);
                if (prod <= (128'd1 << 121)) begin
                    g = c;
                end
            end
            rom[n-1] = g;
        end
        return rom;
    endfunction

    localparam gain_rom_t GAIN_ROM = build_gain_rom();

endpackage

// File: design/cordic_sine_cosine_rotation.sv
// Top level of the rotation-mode CORDIC sine/cosine block.
// Depends on csc_pkg, csc_angle_prep, csc_cell and the assertion header.
//
// Usage: s_angle_deg (signed Q7.16 degrees, saturated to +/-90) enters on a
// valid/ready channel; m_cos_value and m_sin_value (signed Q1.30, clamped to
// +/-1.0) leave on a valid/ready channel, one result transaction per input
// transaction, in order.
// Pipeline: three angle-scaling stages, one cell per micro-rotation, one output
// register. Throughput is one transaction per cycle unless a stalled receiver
// backs up to the chain end; every cell holds one angle in flight.
// When the receiver stalls, the output register holds its result and the cell
// chain keeps moving until a valid result reaches its end; a bubble at the end
// of the chain is squeezed out, so input is still taken in that cycle.
// The APB register last_iteration (address 0) sets the final micro-rotation;
// cells beyond it pass data through. Write it only while the block is empty.
// Reset (aresetn low, synchronous) empties the pipeline and sets
// last_iteration to 31.
module cordic_sine_cosine_rotation #(
    parameter int STAGES     = csc_pkg::STAGES_DEF,
    parameter int DATA_WIDTH = csc_pkg::DATA_WIDTH_DEF
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  logic signed [csc_pkg::ANGLE_W-1:0]     s_angle_deg,
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output logic signed [csc_pkg::RESULT_W-1:0]    m_cos_value,
    output logic signed [csc_pkg::RESULT_W-1:0]    m_sin_value,
    input  logic                                   psel,
    input  logic                                   penable,
    input  logic                                   pwrite,
    input  logic [csc_pkg::APB_ADDR_W-1:0]         paddr,
    input  logic [csc_pkg::APB_DATA_W-1:0]         pwdata,
    output logic [csc_pkg::APB_DATA_W-1:0]         prdata,
    output logic                                   pready
);
    import csc_pkg::*;

`include "cordic_sine_cosine_rotation_assert.svh"

    localparam int NCELL = (STAGES < ROM_SIZE) ? STAGES : ROM_SIZE;
    localparam int FRAC  = DATA_WIDTH - 2;
    localparam int SHR   = (FRAC >= 30) ? FRAC - 30 : 0;
    localparam int SHL   = (FRAC < 30) ? 30 - FRAC : 0;
    localparam int CW    = (DATA_WIDTH > 32) ? DATA_WIDTH : 32;
    localparam logic [ROM_IDX_W-1:0] MAX_IDX = ROM_IDX_W'(NCELL - 1);
    localparam logic signed [CW-1:0] POS_ONE = CW'(ONE_Q30);
    localparam logic signed [CW-1:0] NEG_ONE = -POS_ONE;

    // configuration
    logic [ROM_IDX_W-1:0] last_iteration_reg, last_iteration_next;
    logic [ROM_IDX_W-1:0] last_idx_reg, last_idx_next;
    logic [30:0]          gain_reg;
    logic                 cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb begin
        last_iteration_next = last_iteration_reg;
        if (cfg_write) begin
            unique case (paddr[2])
                REG_LAST_ITERATION: last_iteration_next = pwdata[ROM_IDX_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_LAST_ITERATION: prdata = APB_DATA_W'(last_iteration_reg);
            default:            prdata = '0;
        endcase
    end

    assign last_idx_next = (last_iteration_reg > MAX_IDX) ? MAX_IDX : last_iteration_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_iteration_reg <= LAST_ITER_RESET;
        end else begin
            last_iteration_reg <= last_iteration_next;
        end
    end

    always_ff @(posedge aclk) begin
        last_idx_reg <= last_idx_next;
        gain_reg     <= GAIN_ROM[last_idx_next];
    end

    // pipeline control
    logic advance;
    logic m_valid_reg;
    logic load_out;
    logic [NCELL:0] valid_chain;

    assign advance  = !m_valid_reg || m_ready || !valid_chain[NCELL];
    assign s_ready  = advance;
    assign load_out = !m_valid_reg || m_ready;

    // angle front end
    logic signed [31:0] target;

    csc_angle_prep u_prep (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .en         (advance),
        .valid_in   (s_valid && s_ready),
        .angle_in   (s_angle_deg),
        .valid_out  (valid_chain[0]),
        .target_out (target)
    );

    // start vector
    logic [CW-1:0]                gain_ext;
    logic [CW-1:0]                gain_scaled;
    logic signed [DATA_WIDTH-1:0] x_chain [NCELL+1];
    logic signed [DATA_WIDTH-1:0] y_chain [NCELL+1];
    angle_t                       ang_chain [NCELL+1];

    assign gain_ext              = CW'(gain_reg);
    assign gain_scaled           = (gain_ext << SHR) >> SHL;
    assign x_chain[0]            = $signed(gain_scaled[DATA_WIDTH-1:0]);
    assign y_chain[0]            = '0;
    assign ang_chain[0].alpha    = '0;
    assign ang_chain[0].target   = target;

    for (genvar i = 0; i < NCELL; i++) begin : g_cell
        csc_cell #(
            .INDEX      (i),
            .DATA_WIDTH (DATA_WIDTH)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (advance),
            .last_idx  (last_idx_reg),
            .valid_in  (valid_chain[i]),
            .x_in      (x_chain[i]),
            .y_in      (y_chain[i]),
            .ang_in    (ang_chain[i]),
            .valid_out (valid_chain[i+1]),
            .x_out     (x_chain[i+1]),
            .y_out     (y_chain[i+1]),
            .ang_out   (ang_chain[i+1])
        );
    end

    // output scaling and clamp
    function automatic logic signed [RESULT_W-1:0] to_q30(
        input logic signed [DATA_WIDTH-1:0] v
    );
        logic signed [CW-1:0] ve;
        logic signed [CW-1:0] w;
        ve = CW'(v);
        w  = (ve >>> SHR) <<< SHL;
        if (w > POS_ONE) begin
            w = POS_ONE;
        end else if (w < NEG_ONE) begin
            w = NEG_ONE;
        end
        return RESULT_W'(w);
    endfunction

    logic signed [RESULT_W-1:0] cos_reg, cos_next;
    logic signed [RESULT_W-1:0] sin_reg, sin_next;

    assign cos_next = to_q30(x_chain[NCELL]);
    assign sin_next = to_q30(y_chain[NCELL]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (load_out) begin
            m_valid_reg <= valid_chain[NCELL];
        end
    end

    always_ff @(posedge aclk) begin
        if (load_out) begin
            cos_reg <= cos_next;
            sin_reg <= sin_next;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_cos_value = cos_reg;
    assign m_sin_value = sin_reg;

    // assertions
    `CSC_ASSERT(a_cos_range, m_valid |-> (m_cos_value <= ONE_Q30 && m_cos_value >= -ONE_Q30), "cos out of range")
    `CSC_ASSERT(a_sin_range, m_valid |-> (m_sin_value <= ONE_Q30 && m_sin_value >= -ONE_Q30), "sin out of range")
    `CSC_ASSERT_NEVER(a_ready_empty, !m_valid && !s_ready, "input blocked with empty output")
    `CSC_ASSERT(a_cfg_write, (cfg_write && paddr[2] == REG_LAST_ITERATION) |=> (last_iteration_reg == $past(pwdata[ROM_IDX_W-1:0])), "register write lost")

endmodule

// File: design/csc_angle_prep.sv
// Angle front end: saturation, degree-to-radian scaling in two partial
// products, and sign restore. Three register stages. Uses csc_pkg.
module csc_angle_prep (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                en,
    input  logic                                valid_in,
    input  logic signed [csc_pkg::ANGLE_W-1:0]  angle_in,
    output logic                                valid_out,
    output logic signed [31:0]                  target_out
);
    import csc_pkg::*;

    logic [2:0]               valid_reg;
    logic [2:0]               valid_next;
    logic [MAG_W-1:0]         mag_reg, mag_next;
    logic                     neg_a_reg, neg_a_next;
    logic [43:0]              prod_hi_reg, prod_hi_next;
    logic [42:0]              prod_lo_reg, prod_lo_next;
    logic                     neg_b_reg;
    logic signed [31:0]       target_reg, target_next;
    logic signed [ANGLE_W-1:0] sat;
    logic [63:0]              sum;
    logic [30:0]              tmag;

    always_comb begin
        if (angle_in > ANGLE_LIMIT) begin
            sat = ANGLE_LIMIT;
        end else if (angle_in < -ANGLE_LIMIT) begin
            sat = -ANGLE_LIMIT;
        end else begin
            sat = angle_in;
        end
        neg_a_next = sat[ANGLE_W-1];
        mag_next   = neg_a_next ? MAG_W'(-sat) : MAG_W'(sat);
    end

    assign prod_hi_next = 44'(mag_reg) * 44'(DEG2RAD_HI);
    assign prod_lo_next = 43'(mag_reg) * 43'(DEG2RAD_LO);

    always_comb begin
        sum         = {prod_hi_reg, 20'd0} + 64'(prod_lo_reg);
        tmag        = sum[62:32];
        target_next = neg_b_reg ? -$signed({1'b0, tmag}) : $signed({1'b0, tmag});
    end

    assign valid_next = {valid_reg[1:0], valid_in};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (en) begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            mag_reg     <= mag_next;
            neg_a_reg   <= neg_a_next;
            prod_hi_reg <= prod_hi_next;
            prod_lo_reg <= prod_lo_next;
            neg_b_reg   <= neg_a_reg;
            target_reg  <= target_next;
        end
    end

    assign valid_out  = valid_reg[2];
    assign target_out = target_reg;

endmodule

// File: design/csc_cell.sv
// One CORDIC micro-rotation cell: shift-add on x/y and angle accumulate.
// Bypasses when its index is past the last configured iteration. Uses csc_pkg.
module csc_cell #(
    parameter int INDEX      = 0,
    parameter int DATA_WIDTH = csc_pkg::DATA_WIDTH_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                en,
    input  logic [csc_pkg::ROM_IDX_W-1:0]       last_idx,
    input  logic                                valid_in,
    input  logic signed [DATA_WIDTH-1:0]        x_in,
    input  logic signed [DATA_WIDTH-1:0]        y_in,
    input  csc_pkg::angle_t                     ang_in,
    output logic                                valid_out,
    output logic signed [DATA_WIDTH-1:0]        x_out,
    output logic signed [DATA_WIDTH-1:0]        y_out,
    output csc_pkg::angle_t                     ang_out
);
    import csc_pkg::*;

    localparam logic signed [31:0] ATAN_STEP = $signed({2'b00, ATAN_ROM[INDEX]});

    logic                         valid_reg;
    logic signed [DATA_WIDTH-1:0] x_reg, x_next;
    logic signed [DATA_WIDTH-1:0] y_reg, y_next;
    angle_t                       ang_reg, ang_next;
    logic signed [DATA_WIDTH-1:0] xs;
    logic signed [DATA_WIDTH-1:0] ys;
    logic                         active;

    assign xs     = x_in >>> INDEX;
    assign ys     = y_in >>> INDEX;
    assign active = (ROM_IDX_W'(INDEX) <= last_idx);

    always_comb begin
        ang_next.target = ang_in.target;
        if (!active) begin
            x_next         = x_in;
            y_next         = y_in;
            ang_next.alpha = ang_in.alpha;
        end else if (ang_in.alpha < ang_in.target) begin
            x_next         = x_in - ys;
            y_next         = y_in + xs;
            ang_next.alpha = ang_in.alpha + ATAN_STEP;
        end else begin
            x_next         = x_in + ys;
            y_next         = y_in - xs;
            ang_next.alpha = ang_in.alpha - ATAN_STEP;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            x_reg   <= x_next;
            y_reg   <= y_next;
            ang_reg <= ang_next;
        end
    end

    assign valid_out = valid_reg;
    assign x_out     = x_reg;
    assign y_out     = y_reg;
    assign ang_out   = ang_reg;

endmodule
